[hdl/pmmh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pmmh_pkg;
    localparam int COEFF_COUNT = 169;
    localparam int COEFF_AW    = 8;
    localparam int OFS_W2      = 80;
    localparam int OFS_W3      = 144;
    localparam int OFS_B1      = 152;
    localparam int OFS_B2      = 160;
    localparam int OFS_B3      = 168;
    localparam int ACC_W       = 40;

    localparam logic [2:0] REG_SIDE   = 3'd0;
    localparam logic [2:0] REG_XBASE  = 3'd1;
    localparam logic [2:0] REG_XSTEP  = 3'd2;
    localparam logic [2:0] REG_YBASE  = 3'd3;
    localparam logic [2:0] REG_YSTEP  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_COORD, S_L1, S_L2, S_L3, S_SIG, S_OUT
    } t_state;

    function automatic logic [16:0] sig_tab(input logic [5:0] k);
        logic [16:0] v;
        begin
            case (k)
                6'd0: v = 17'd22;     6'd1: v = 17'd36;     6'd2: v = 17'd60;
                6'd3: v = 17'd98;     6'd4: v = 17'd162;    6'd5: v = 17'd267;
                6'd6: v = 17'd439;    6'd7: v = 17'd720;    6'd8: v = 17'd1179;
                6'd9: v = 17'd1921;   6'd10: v = 17'd3108;  6'd11: v = 17'd4971;
                6'd12: v = 17'd7812;  6'd13: v = 17'd11955; 6'd14: v = 17'd17625;
                6'd15: v = 17'd24743; 6'd16: v = 17'd32768; 6'd17: v = 17'd40793;
                6'd18: v = 17'd47911; 6'd19: v = 17'd53581; 6'd20: v = 17'd57724;
                6'd21: v = 17'd60565; 6'd22: v = 17'd62428; 6'd23: v = 17'd63615;
                6'd24: v = 17'd64357; 6'd25: v = 17'd64816; 6'd26: v = 17'd65097;
                6'd27: v = 17'd65269; 6'd28: v = 17'd65374; 6'd29: v = 17'd65438;
                6'd30: v = 17'd65476; 6'd31: v = 17'd65500; 6'd32: v = 17'd65514;
                default: v = 17'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [15:0] narrow(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-13:0] q;
        begin
            q = a[ACC_W-1:12];
            if (q > 32767) return 16'sh7fff;
            else if (q < -32768) return 16'sh8000;
            else return q[15:0];
        end
    endfunction

    function automatic logic signed [15:0] relu_n(input logic signed [ACC_W-1:0] a);
        logic signed [15:0] v;
        begin
            v = narrow(a);
            return v[15] ? 16'sd0 : v;
        end
    endfunction
endpackage
`default_nettype wire

[hdl/per_pixel_mlp_mask_head_unit.sv]
// Per-pixel MLP mask head.
// Input channel (i_valid/o_ready): op 0 writes coeff_value to slot coeff_index
// (slots above 168 ignored); op 1 evaluates one pixel with eight features.
// Output channel (o_valid/i_ready): one item per pixel: probability, column,
// row, last_of_plane. Load items give no output and are taken one per cycle
// while no pixel is in work. A pixel item first computes the coordinates, then
// makes one coefficient store read per cycle, lane by lane (88 layer-one reads
// with biases, 72 layer-two reads with biases, 9 layer-three reads); the last
// layer-three sum is then registered, the sigmoid registers its result, and the
// output register is loaded. The single read port of the coefficient memory
// sets the pace. One pixel is in work at a time; the next item is accepted in
// the cycle after the output register is loaded.
// A result waiting on i_ready holds the next pixel once it reaches the output
// stage; loads are not accepted while it is held there.
// Reset (synchronous, active low) clears state, counters and configuration
// registers to defaults (side 160, offsets and steps 0); the coefficient
// store is undefined until loaded. Configuration writes (i_cfg_we, i_cfg_index,
// i_cfg_data) take effect at once and must only occur while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module per_pixel_mlp_mask_head_unit
    import pmmh_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_op,
    input  wire logic [7:0]         i_coeff_index,
    input  wire logic signed [15:0] i_coeff_value,
    input  wire logic signed [15:0] i_feature_0,
    input  wire logic signed [15:0] i_feature_1,
    input  wire logic signed [15:0] i_feature_2,
    input  wire logic signed [15:0] i_feature_3,
    input  wire logic signed [15:0] i_feature_4,
    input  wire logic signed [15:0] i_feature_5,
    input  wire logic signed [15:0] i_feature_6,
    input  wire logic signed [15:0] i_feature_7,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [15:0]             o_probability,
    output logic [7:0]              o_column,
    output logic [7:0]              o_row,
    output logic                    o_last_of_plane
);
    logic [8:0]         r_side;
    logic signed [23:0] r_xb, r_xs, r_yb, r_ys;
    logic [7:0]         r_col, r_row;
    t_state             r_state, n_state;
    logic [3:0]         r_cnt, n_cnt;
    logic               r_rd_v;
    logic [3:0]         r_rd_i;
    logic signed [15:0] r_x [10];
    logic signed [15:0] r_h [8];
    logic signed [ACC_W-1:0] r_acc [8];
    logic signed [15:0] r_l3;
    logic [15:0]        prob;
    logic [15:0]        r_prob;

    logic               acc_in, do_load;
    logic               out_load;
    logic [COEFF_AW-1:0] raddr;
    logic [15:0]        rdata;
    logic [8:0]         side_eff;
    logic               col_end, row_end;
    logic [2:0]         lane;

    assign acc_in   = i_valid && o_ready;
    assign do_load  = acc_in && !i_op && (i_coeff_index < 8'(COEFF_COUNT));
    assign out_load = (r_state == S_OUT) && (!o_valid || i_ready);

    pmmh_coeff_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (do_load),
        .i_waddr(i_coeff_index),
        .i_wdata(i_coeff_value),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    pmmh_sigmoid u_sig (
        .i_clk(i_clk),
        .i_q  (r_l3),
        .o_p  (prob)
    );

    always_comb begin
        side_eff = r_side;
        if (side_eff == 9'd0) side_eff = 9'd1;
        if (side_eff > 9'd256) side_eff = 9'd256;
    end
    assign col_end = (10'(r_col) + 10'd1) >= 10'(side_eff);
    assign row_end = (10'(r_row) + 10'd1) >= 10'(side_eff);

    // Address sequencing: L1 reads input column i for all 8 lanes would need 8
    // reads; instead each read feeds one lane over a lane-major walk.
    // Layer steps: cnt walks 0..(n-1) inputs; lane walks 0..7.
    logic [2:0] r_lane, n_lane;
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_lane  = r_lane;
        raddr   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (acc_in && i_op) n_state = S_COORD;
            end
            S_COORD: begin
                n_state = S_L1;
                n_cnt   = '0;
                n_lane  = '0;
            end
            S_L1: begin
                // cnt 0..9 weights, cnt 10 bias
                raddr = (r_cnt == 4'd10) ? 8'(OFS_B1 + 32'(r_lane))
                                         : 8'(32'(r_lane) * 10 + 32'(r_cnt));
                if (r_cnt == 4'd10) begin
                    n_cnt = '0;
                    n_lane = r_lane + 3'd1;
                    if (r_lane == 3'd7) n_state = S_L2;
                end else n_cnt = r_cnt + 4'd1;
            end
            S_L2: begin
                raddr = (r_cnt == 4'd8) ? 8'(OFS_B2 + 32'(r_lane))
                                        : 8'(OFS_W2 + 32'(r_lane) * 8 + 32'(r_cnt));
                if (r_cnt == 4'd8) begin
                    n_cnt = '0;
                    n_lane = r_lane + 3'd1;
                    if (r_lane == 3'd7) n_state = S_L3;
                end else n_cnt = r_cnt + 4'd1;
            end
            S_L3: begin
                raddr = (r_cnt == 4'd8) ? 8'(OFS_B3) : 8'(OFS_W3 + 32'(r_cnt));
                if (r_cnt == 4'd8) begin
                    n_cnt = '0;
                    n_state = S_SIG;
                end else n_cnt = r_cnt + 4'd1;
            end
            S_SIG: begin
                if (!r_rd_v) n_state = S_OUT;
            end
            S_OUT: begin
                if (!o_valid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // read tag: which layer/lane/index the returning data belongs to
    t_state             r_rd_st;
    logic [2:0]         r_rd_lane;
    logic signed [31:0] mul;
    logic signed [15:0] opnd;

    always_comb begin
        lane = r_rd_lane;
        if (r_rd_st == S_L1) opnd = r_x[r_rd_i];
        else opnd = r_h[r_rd_i[2:0]];
    end
    assign mul = $signed(rdata) * opnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_lane    <= '0;
            r_rd_v    <= 1'b0;
            o_valid   <= 1'b0;
            r_side    <= 9'd160;
            r_xb <= '0; r_xs <= '0; r_yb <= '0; r_ys <= '0;
            r_col <= '0; r_row <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_lane  <= n_lane;
            r_state <= n_state;
            r_rd_v  <= (r_state == S_L1) || (r_state == S_L2) || (r_state == S_L3);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SIDE:  r_side <= i_cfg_data[8:0];
                    REG_XBASE: r_xb <= i_cfg_data;
                    REG_XSTEP: r_xs <= i_cfg_data;
                    REG_YBASE: r_yb <= i_cfg_data;
                    REG_YSTEP: r_ys <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            if (out_load) begin
                o_valid <= 1'b1;
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? 8'd0 : r_row + 8'd1;
                end else r_col <= r_col + 8'd1;
            end
        end
    end

    logic signed [35:0] xprod, yprod;
    logic signed [36:0] xsum, ysum;
    assign xprod = r_xs * $signed({4'd0, r_col});
    assign yprod = r_ys * $signed({4'd0, r_row});
    assign xsum  = 37'(xprod) + 37'(r_xb);
    assign ysum  = 37'(yprod) + 37'(r_yb);

    function automatic logic signed [15:0] sat37(input logic signed [36:0] v);
        if (v > 37'sd32767) return 16'sh7fff;
        else if (v < -37'sd32768) return 16'sh8000;
        else return v[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        r_rd_st   <= r_state;
        r_rd_lane <= (r_state == S_L3) ? 3'd0 : r_lane;
        r_rd_i    <= r_cnt;
        if (acc_in && i_op) begin
            r_x[2] <= i_feature_0; r_x[3] <= i_feature_1;
            r_x[4] <= i_feature_2; r_x[5] <= i_feature_3;
            r_x[6] <= i_feature_4; r_x[7] <= i_feature_5;
            r_x[8] <= i_feature_6; r_x[9] <= i_feature_7;
        end
        if (r_state == S_COORD) begin
            r_x[0] <= sat37(xsum);
            r_x[1] <= sat37(ysum);
        end
        if (r_rd_v) begin
            if ((r_rd_st == S_L1 && r_rd_i == 4'd10) ||
                ((r_rd_st == S_L2 || r_rd_st == S_L3) && r_rd_i == 4'd8)) begin
                r_acc[lane] <= r_acc[lane] + ACC_W'($signed({rdata, 12'd0}));
            end else if (r_rd_i == 4'd0) begin
                r_acc[lane] <= ACC_W'(mul);
            end else begin
                r_acc[lane] <= r_acc[lane] + ACC_W'(mul);
            end
        end
        // after layer 1 done (first L2 read starts), latch h1
        if (r_rd_v && r_rd_st == S_L1 && r_rd_i == 4'd10 && lane == 3'd7) begin
            for (int j = 0; j < 7; j++) r_h[j] <= relu_n(r_acc[j]);
            r_h[7] <= relu_n(r_acc[7] + ACC_W'($signed({rdata, 12'd0})));
        end
        if (r_rd_v && r_rd_st == S_L2 && r_rd_i == 4'd8 && lane == 3'd7) begin
            for (int j = 0; j < 7; j++) r_h[j] <= relu_n(r_acc[j]);
            r_h[7] <= relu_n(r_acc[7] + ACC_W'($signed({rdata, 12'd0})));
        end
        if (r_rd_v && r_rd_st == S_L3 && r_rd_i == 4'd8) begin
            r_l3 <= narrow(r_acc[0] + ACC_W'($signed({rdata, 12'd0})));
        end
        if (out_load) begin
            r_prob   <= prob;
            o_column <= r_col;
            o_row    <= r_row;
            o_last_of_plane <= col_end && row_end;
        end
    end

    assign o_probability = r_prob;
endmodule
`default_nettype wire

[hdl/pmmh_coeff_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module pmmh_coeff_ram
    import pmmh_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [COEFF_AW-1:0] i_waddr,
    input  wire logic [15:0]         i_wdata,
    input  wire logic [COEFF_AW-1:0] i_raddr,
    output logic [15:0]              o_rdata
);
    logic [15:0] r_mem [COEFF_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hdl/pmmh_sigmoid.sv]
`timescale 1ns / 1ps
`default_nettype none
module pmmh_sigmoid
    import pmmh_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic signed [15:0] i_q,
    output logic [15:0]             o_p
);
    logic [15:0] u;
    logic [5:0]  k;
    logic [16:0] t0, t1;
    logic [27:0] prod;
    logic [17:0] p;

    assign u    = {~i_q[15], i_q[14:0]};
    assign k    = {1'b0, u[15:11]};
    assign t0   = sig_tab(k);
    assign t1   = sig_tab(k + 6'd1);
    assign prod = 28'(t1 - t0) * 28'(u[10:0]);
    assign p    = 18'(t0) + 18'(prod[27:11]);

    always_ff @(posedge i_clk) begin
        o_p <= (p > 18'd65535) ? 16'hffff : p[15:0];
    end
endmodule
`default_nettype wire

[hdl/pmmh_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module pmmh_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       i_op,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_column,
    input wire logic [7:0] o_row,
    input wire logic [15:0] o_probability
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_probability) &&
        $stable(o_column) && $stable(o_row))
        else $error("output item changed while stalled");
    a_busy_after_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_op |=> !o_ready)
        else $error("ready during pixel work");
    a_no_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_op && !o_valid |=> !o_valid)
        else $error("output after load item");
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule

bind per_pixel_mlp_mask_head_unit pmmh_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_op(i_op), .o_valid(o_valid), .i_ready(i_ready), .o_column(o_column),
    .o_row(o_row), .o_probability(o_probability)
);
`default_nettype wire

[tb/per_pixel_mlp_mask_head_unit_tb.sv]
`timescale 1ns / 1ps
module per_pixel_mlp_mask_head_unit_tb;
    import pmmh_pkg::*;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;
    localparam int   STALL_LIMIT = 5000;
    localparam int   HOLD_CYCLES = 1000;
    localparam int   SETTLE = 40;

    typedef struct packed {
        logic [15:0] prob;
        logic [7:0]  col;
        logic [7:0]  row;
        logic        last;
    } pix_res_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  idx;
        logic [15:0] val;
        logic [15:0] feat;
        logic        chk;
        logic [15:0] prob;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_op = 1'b0;
    logic [7:0]  i_coeff_index = '0;
    logic signed [15:0] i_coeff_value = '0;
    logic [7:0][15:0] feat_bus = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_probability;
    logic [7:0]  o_column;
    logic [7:0]  o_row;
    logic        o_last_of_plane;

    per_pixel_mlp_mask_head_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_op(i_op),
        .i_coeff_index(i_coeff_index), .i_coeff_value(i_coeff_value),
        .i_feature_0(feat_bus[0]), .i_feature_1(feat_bus[1]),
        .i_feature_2(feat_bus[2]), .i_feature_3(feat_bus[3]),
        .i_feature_4(feat_bus[4]), .i_feature_5(feat_bus[5]),
        .i_feature_6(feat_bus[6]), .i_feature_7(feat_bus[7]),
        .o_valid(o_valid), .i_ready(i_ready), .o_probability(o_probability),
        .o_column(o_column), .o_row(o_row), .o_last_of_plane(o_last_of_plane)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of the block
    logic signed [15:0] coeff_mirror [COEFF_COUNT];
    int unsigned side_reg = 160;
    int x_base = 0, x_step = 0, y_base = 0, y_step = 0;
    int col_cnt = 0, row_cnt = 0;
    int sig_lut [33] = '{22, 36, 60, 98, 162, 267, 439, 720, 1179, 1921, 3108, 4971,
        7812, 11955, 17625, 24743, 32768, 40793, 47911, 53581, 57724, 60565, 62428,
        63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};

    pix_res_t prob_q [$];
    int errors = 0;
    bit no_idle = 0;
    int hold_seq = 0, hold_seen = 0;
    int rdy_cnt = 0;
    int quiet = 0;

    function automatic longint sat_q(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint floor_sat(input longint acc);
        return sat_q(acc >>> 12);
    endfunction

    function automatic longint relu(input longint v);
        return v < 0 ? 0 : v;
    endfunction

    function automatic pix_res_t eval_pixel(input logic [7:0][15:0] ft);
        longint x [10];
        longint h1 [8];
        longint h2 [8];
        longint acc, q3;
        int s, c, r, u, k, f, p;
        pix_res_t res;
        s = side_reg;
        if (s < 1) s = 1;
        if (s > 256) s = 256;
        c = col_cnt;
        r = row_cnt;
        x[0] = sat_q(longint'(x_base) + longint'(x_step) * c);
        x[1] = sat_q(longint'(y_base) + longint'(y_step) * r);
        for (int i = 0; i < 8; i++) x[2+i] = longint'($signed(ft[i]));
        for (int o = 0; o < 8; o++) begin
            acc = longint'(coeff_mirror[OFS_B1+o]) * 4096;
            for (int i = 0; i < 10; i++) acc += longint'(coeff_mirror[o*10+i]) * x[i];
            h1[o] = relu(floor_sat(acc));
        end
        for (int o = 0; o < 8; o++) begin
            acc = longint'(coeff_mirror[OFS_B2+o]) * 4096;
            for (int i = 0; i < 8; i++)
                acc += longint'(coeff_mirror[OFS_W2+o*8+i]) * h1[i];
            h2[o] = relu(floor_sat(acc));
        end
        acc = longint'(coeff_mirror[OFS_B3]) * 4096;
        for (int i = 0; i < 8; i++) acc += longint'(coeff_mirror[OFS_W3+i]) * h2[i];
        q3 = floor_sat(acc);
        u = int'(q3) + 32768;
        k = u >> 11;
        f = u & 2047;
        p = sig_lut[k] + (((sig_lut[k+1] - sig_lut[k]) * f) >> 11);
        if (p > 65535) p = 65535;
        res.prob = p[15:0];
        res.col = c[7:0];
        res.row = r[7:0];
        res.last = (c + 1 >= s) && (r + 1 >= s);
        if (c + 1 >= s) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= s) ? 0 : ((r + 1) & 255);
        end else begin
            col_cnt = (c + 1) & 255;
        end
        return res;
    endfunction

    function automatic logic [15:0] rand_q12();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3, 4: return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send(input logic op, input logic [7:0] idx, input logic [15:0] val,
                        input logic [7:0][15:0] ft, input bit chk, input logic [15:0] prob);
        int gap;
        pix_res_t res;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_coeff_index <= idx;
        i_coeff_value <= val;
        feat_bus <= ft;
        do @(posedge i_clk); while (!o_ready);
        if (op == OP_LOAD) begin
            if (idx < COEFF_COUNT) coeff_mirror[idx] = val;
        end else begin
            res = eval_pixel(ft);
            if (chk) res.prob = prob;
            prob_q.push_back(res);
        end
    endtask

    task automatic send_rand_load();
        logic [7:0] idx;
        idx = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(169, 255))
                                           : 8'($urandom_range(0, 168));
        send(OP_LOAD, idx, rand_q12(), 128'($urandom) << 64 | 128'($urandom), 0, '0);
    endtask

    task automatic send_rand_pixel();
        logic [7:0][15:0] ft;
        for (int i = 0; i < 8; i++) ft[i] = rand_q12();
        send(OP_PIXEL, 8'($urandom), 16'($urandom), ft, 0, '0);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (prob_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] index, input logic [23:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        case (index)
            REG_SIDE:  side_reg = data[8:0];
            REG_XBASE: x_base = int'($signed(data));
            REG_XSTEP: x_step = int'($signed(data));
            REG_YBASE: y_base = int'($signed(data));
            REG_YSTEP: y_step = int'($signed(data));
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] rand_rel();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'h000000;
            3, 4: return 24'($urandom_range(0, 16383) - 8192);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_side();
        case ($urandom_range(0, 7))
            0: return 24'd0;
            1: return 24'd1;
            2: return 24'd256;
            3: return 24'd511;
            4: return 24'($urandom_range(0, 511));
            default: return 24'($urandom_range(2, 6));
        endcase
    endfunction

    dir_row_t dir_tab [20] = '{
        '{OP_PIXEL, 8'd0,   16'h0000, 16'h0000, 1'b1, 16'd32768},
        '{OP_PIXEL, 8'd0,   16'h0000, 16'h7fff, 1'b1, 16'd32768},
        '{OP_LOAD,  8'd168, 16'h7fff, 16'h0000, 1'b0, 16'd0},
        '{OP_PIXEL, 8'd0,   16'h0000, 16'h0000, 1'b1, 16'd65513},
        '{OP_LOAD,  8'd168, 16'h8000, 16'h0000, 1'b0, 16'd0},
        '{OP_PIXEL, 8'd0,   16'h0000, 16'h8000, 1'b1, 16'd22},
        '{OP_LOAD,  8'd200, 16'h1234, 16'h0000, 1'b0, 16'd0},
        '{OP_LOAD,  8'd255, 16'h7fff, 16'h0000, 1'b0, 16'd0},
        '{OP_PIXEL, 8'd0,   16'h0000, 16'h0000, 1'b1, 16'd22},
        '{OP_LOAD,  8'd168, 16'h0000, 16'h0000, 1'b0, 16'd0},
        '{OP_LOAD,  8'd2,   16'h7fff, 16'h0000, 1'b0, 16'd0},
        '{OP_LOAD,  8'd144, 16'h7fff, 16'h0000, 1'b0, 16'd0},
        '{OP_PIXEL, 8'd0,   16'h0000, 16'h7fff, 1'b0, 16'd0},
        '{OP_PIXEL, 8'd0,   16'h0000, 16'h8000, 1'b0, 16'd0},
        '{OP_LOAD,  8'd152, 16'h8000, 16'h0000, 1'b0, 16'd0},
        '{OP_PIXEL, 8'd0,   16'h0000, 16'h7fff, 1'b0, 16'd0},
        '{OP_LOAD,  8'd80,  16'h7fff, 16'h0000, 1'b0, 16'd0},
        '{OP_LOAD,  8'd160, 16'h7fff, 16'h0000, 1'b0, 16'd0},
        '{OP_PIXEL, 8'd0,   16'h0000, 16'h1000, 1'b0, 16'd0},
        '{OP_PIXEL, 8'd0,   16'h0000, 16'hffff, 1'b0, 16'd0}
    };

    // result side
    always @(posedge i_clk) begin
        pix_res_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rdy_cnt = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (prob_q.size() == 0) begin
                    $display("%0t: unexpected result prob=%0d col=%0d row=%0d last=%0d",
                             $time, o_probability, o_column, o_row, o_last_of_plane);
                    errors++;
                end else begin
                    want = prob_q.pop_front();
                    if (o_probability !== want.prob) begin
                        $display("%0t: probability exp %0d got %0d", $time, want.prob,
                                 o_probability);
                        errors++;
                    end
                    if (o_column !== want.col) begin
                        $display("%0t: column exp %0d got %0d", $time, want.col, o_column);
                        errors++;
                    end
                    if (o_row !== want.row) begin
                        $display("%0t: row exp %0d got %0d", $time, want.row, o_row);
                        errors++;
                    end
                    if (o_last_of_plane !== want.last) begin
                        $display("%0t: last_of_plane exp %0d got %0d", $time, want.last,
                                 o_last_of_plane);
                        errors++;
                    end
                end
                rdy_cnt = no_idle ? 0 : $urandom_range(0, 18);
            end else if (rdy_cnt > 0) begin
                rdy_cnt--;
            end
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                rdy_cnt = HOLD_CYCLES;
            end
            i_ready <= (rdy_cnt == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("per_pixel_mlp_mask_head_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [7:0][15:0] ft;
        int n_items;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        no_idle = 1;
        for (int i = 0; i < COEFF_COUNT; i++) send(OP_LOAD, 8'(i), 16'h0000, '0, 0, '0);
        no_idle = 0;
        foreach (dir_tab[r]) begin
            ft = {8{dir_tab[r].feat}};
            send(dir_tab[r].op, dir_tab[r].idx, dir_tab[r].val, ft,
                 dir_tab[r].chk, dir_tab[r].prob);
        end

        for (int ph = 0; ph < 16; ph++) begin
            drain();
            cfg_write(REG_SIDE, (ph == 0) ? 24'd0 : (ph == 1) ? 24'd511 : rand_side());
            cfg_write(REG_XBASE, rand_rel());
            cfg_write(REG_XSTEP, rand_rel());
            cfg_write(REG_YBASE, rand_rel());
            cfg_write(REG_YSTEP, rand_rel());
            if ($urandom_range(0, 3) == 0) cfg_write(3'($urandom_range(5, 7)), 24'($urandom));
            cfg_done();
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 15)) send_rand_load();
            if (ph == 3) hold_seq++;
            n_items = $urandom_range(10, 30);
            for (int k = 0; k < n_items; k++) begin
                if (ph == 7 && k == n_items / 2) drain();
                if ($urandom_range(0, 4) == 0) send_rand_load();
                else send_rand_pixel();
            end
        end

        drain();
        if (errors == 0) begin
            $display("per_pixel_mlp_mask_head_unit_tb OK");
        end else begin
            $display("per_pixel_mlp_mask_head_unit_tb NOT OK");
        end
        $finish;
    end
endmodule
